// File: hw/rtl/icalc_pkg.sv
// Shared types, codes and defaults for the integer calculator ALU.
`timescale 1ns / 1ps
`default_nettype none

package icalc_pkg;

    localparam int DEF_OPERAND_WIDTH = 32;
    localparam int DEF_FRACTION_BITS = 16;
    localparam int QUEUE_DEPTH       = 4;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_REM  = 3'd4,
        OP_POW  = 3'd5,
        OP_SQRT = 3'd6,
        OP_CBRT = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_DIV_ZERO  = 2'd1,
        ST_ROOT_NEG  = 2'd2,
        ST_OVERFLOW  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        JK_ADD,
        JK_SUB,
        JK_MUL,
        JK_DIV,
        JK_REM,
        JK_PPOW,
        JK_NPOW,
        JK_SQRT,
        JK_CBRT,
        JK_FAULT
    } job_kind_t;

    typedef struct packed {
        job_kind_t kind;
        status_t   fault;
        logic      neg;
    } job_ctl_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_MUL,
        BK_PLO,
        BK_PHI,
        BK_NPW,
        BK_DSET,
        BK_DIV,
        BK_ROOT,
        BK_RFIX,
        BK_SIGN,
        BK_FIN
    } bk_state_t;

endpackage

`default_nettype wire

// File: hw/rtl/integer_calculator_alu_top.sv
// Top level of the integer calculator ALU: front end, job queue, back end.
// Each input word (operation, two signed operands) gives one output word: a signed
// 64-bit floor part, 16 fraction bits and a status code. The front end classifies
// words into a four-deep job queue; the back end runs one job at a time through a
// shared 32-by-OPERAND_WIDTH multiplier, a one-bit-per-cycle restoring divider and a
// digit-by-digit root unit. Add, subtract and the fault cases leave at one word per
// cycle while the back end is idle and the receiver is ready. Multiply passes
// through the multiply, sign and finish states; divide and remainder form
// max(OPERAND_WIDTH, FRACTION_BITS+2) quotient bits; a non-negative power runs a
// low and a high partial product per multiply and stops at saturation; a negative
// power multiplies until the divisor exceeds 2^FRACTION_BITS or the exponent runs
// out, then divides once; square root forms (OPERAND_WIDTH+2*FRACTION_BITS+1)/2 and
// cube root (OPERAND_WIDTH+3*FRACTION_BITS+2)/3 digits, one root digit per cycle.
// The front end keeps accepting words while the back end works until the queue fills.
`timescale 1ns / 1ps
`default_nettype none

module integer_calculator_alu_top
    import icalc_pkg::*;
#(
    parameter int OPERAND_WIDTH = DEF_OPERAND_WIDTH,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [2:0]         operation,
    input  wire logic signed [31:0] first_operand,
    input  wire logic signed [31:0] second_operand,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [63:0]      result_whole,
    output logic [15:0]             result_fraction,
    output logic [1:0]              status
);

    localparam int W  = OPERAND_WIDTH;
    localparam int QW = $bits(job_ctl_t) + 4 * W;

    logic           f_valid;
    logic           f_ready;
    job_ctl_t       f_ctl;
    logic [W-1:0]   f_a;
    logic [W-1:0]   f_b;
    logic [W-1:0]   f_ma;
    logic [W-1:0]   f_mb;
    logic [QW-1:0]  q_in;
    logic [QW-1:0]  q_out;
    logic           j_valid;
    logic           j_ready;
    job_ctl_t       j_ctl;
    logic [W-1:0]   j_a;
    logic [W-1:0]   j_b;
    logic [W-1:0]   j_ma;
    logic [W-1:0]   j_mb;

    icalc_front #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .first_operand  (first_operand),
        .second_operand (second_operand),
        .f_valid        (f_valid),
        .f_ready        (f_ready),
        .f_ctl          (f_ctl),
        .f_a            (f_a),
        .f_b            (f_b),
        .f_ma           (f_ma),
        .f_mb           (f_mb)
    );

    assign q_in = {f_ctl, f_a, f_b, f_ma, f_mb};

    icalc_queue #(
        .DATA_W (QW),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (q_in),
        .pop_valid  (j_valid),
        .pop_ready  (j_ready),
        .pop_data   (q_out)
    );

    assign {j_ctl, j_a, j_b, j_ma, j_mb} = q_out;

    icalc_back #(
        .OPERAND_WIDTH (OPERAND_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .j_valid         (j_valid),
        .j_ready         (j_ready),
        .j_ctl           (j_ctl),
        .j_a             (j_a),
        .j_b             (j_b),
        .j_ma            (j_ma),
        .j_mb            (j_mb),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .result_whole    (result_whole),
        .result_fraction (result_fraction),
        .status          (status)
    );

endmodule

`default_nettype wire

// File: hw/rtl/icalc_front.sv
// Front end: takes input words, forms operand magnitudes and classifies them into jobs.
`timescale 1ns / 1ps
`default_nettype none

module icalc_front
    import icalc_pkg::*;
#(
    parameter int OPERAND_WIDTH = DEF_OPERAND_WIDTH
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [2:0]               operation,
    input  wire logic signed [31:0]       first_operand,
    input  wire logic signed [31:0]       second_operand,
    output logic                          f_valid,
    input  wire logic                     f_ready,
    output job_ctl_t                      f_ctl,
    output logic [OPERAND_WIDTH-1:0]      f_a,
    output logic [OPERAND_WIDTH-1:0]      f_b,
    output logic [OPERAND_WIDTH-1:0]      f_ma,
    output logic [OPERAND_WIDTH-1:0]      f_mb
);

    localparam int W = OPERAND_WIDTH;

    logic           fv_reg;
    job_ctl_t       ctl_reg;
    logic [W-1:0]   a_reg;
    logic [W-1:0]   b_reg;
    logic [W-1:0]   ma_reg;
    logic [W-1:0]   mb_reg;

    logic [W-1:0]   a;
    logic [W-1:0]   b;
    logic [W-1:0]   ma;
    logic [W-1:0]   mb;
    logic           sa;
    logic           sb;
    job_ctl_t       ctl;
    op_t            op;
    logic           in_fire;

    assign a  = first_operand[W-1:0];
    assign b  = second_operand[W-1:0];
    assign sa = a[W-1];
    assign sb = b[W-1];
    assign ma = sa ? (~a + W'(1)) : a;
    assign mb = sb ? (~b + W'(1)) : b;
    assign op = op_t'(operation);

    always_comb
    begin
        ctl.kind  = JK_ADD;
        ctl.fault = ST_OK;
        ctl.neg   = 1'b0;
        unique case (op)
            OP_ADD:  ctl.kind = JK_ADD;
            OP_SUB:  ctl.kind = JK_SUB;
            OP_MUL:
            begin
                ctl.kind = JK_MUL;
                ctl.neg  = sa ^ sb;
            end
            OP_DIV:
            begin
                ctl.kind  = (b == '0) ? JK_FAULT : JK_DIV;
                ctl.fault = (b == '0) ? ST_DIV_ZERO : ST_OK;
                ctl.neg   = sa ^ sb;
            end
            OP_REM:
            begin
                ctl.kind  = (b == '0) ? JK_FAULT : JK_REM;
                ctl.fault = (b == '0) ? ST_DIV_ZERO : ST_OK;
                ctl.neg   = sa;
            end
            OP_POW:
            begin
                ctl.neg = sa & b[0];
                priority if (!sb)
                    ctl.kind = JK_PPOW;
                else if (a == '0)
                begin
                    ctl.kind  = JK_FAULT;
                    ctl.fault = ST_DIV_ZERO;
                end
                else
                    ctl.kind = JK_NPOW;
            end
            OP_SQRT:
            begin
                ctl.kind  = sa ? JK_FAULT : JK_SQRT;
                ctl.fault = sa ? ST_ROOT_NEG : ST_OK;
            end
            OP_CBRT:
            begin
                ctl.kind = JK_CBRT;
                ctl.neg  = sa;
            end
        endcase
    end

    assign in_ready = !fv_reg || f_ready;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fv_reg <= 1'b0;
        else if (in_ready)
            fv_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ctl_reg <= ctl;
            a_reg   <= a;
            b_reg   <= b;
            ma_reg  <= ma;
            mb_reg  <= mb;
        end
    end

    assign f_valid = fv_reg;
    assign f_ctl   = ctl_reg;
    assign f_a     = a_reg;
    assign f_b     = b_reg;
    assign f_ma    = ma_reg;
    assign f_mb    = mb_reg;

endmodule

`default_nettype wire

// File: hw/rtl/icalc_queue.sv
// Small job queue between the front end and the execution back end.
`timescale 1ns / 1ps
`default_nettype none

module icalc_queue
    import icalc_pkg::*;
#(
    parameter int DATA_W = 8,
    parameter int DEPTH  = QUEUE_DEPTH
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push_valid,
    output logic                   push_ready,
    input  wire logic [DATA_W-1:0] push_data,
    output logic                   pop_valid,
    input  wire logic              pop_ready,
    output logic [DATA_W-1:0]      pop_data
);

    localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] data_reg [DEPTH];
    logic [PTRW-1:0]   wr_ptr_reg;
    logic [PTRW-1:0]   rd_ptr_reg;
    logic [CNTW-1:0]   count_reg;
    logic              push;
    logic              pop;

    assign push_ready = (count_reg != CNTW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = data_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTRW'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTRW'(1);
            if (push && !pop)
                count_reg <= count_reg + CNTW'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNTW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            data_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// File: hw/rtl/icalc_back.sv
// Back end: sequencer with shared multiplier, divider and root unit, output register.
`timescale 1ns / 1ps
`default_nettype none

module icalc_back
    import icalc_pkg::*;
#(
    parameter int OPERAND_WIDTH = DEF_OPERAND_WIDTH,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     j_valid,
    output logic                          j_ready,
    input  wire job_ctl_t                 j_ctl,
    input  wire logic [OPERAND_WIDTH-1:0] j_a,
    input  wire logic [OPERAND_WIDTH-1:0] j_b,
    input  wire logic [OPERAND_WIDTH-1:0] j_ma,
    input  wire logic [OPERAND_WIDTH-1:0] j_mb,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic signed [63:0]            result_whole,
    output logic [15:0]                   result_fraction,
    output logic [1:0]                    status
);

    localparam int W     = OPERAND_WIDTH;
    localparam int F     = FRACTION_BITS;
    localparam int DW    = (W > F + 2) ? W : F + 2;
    localparam int RS    = (W + 2 * F + 1) / 2;
    localparam int RC    = (W + 3 * F + 2) / 3;
    localparam int RW    = (RS > RC) ? RS : RC;
    localparam int TWM   = (2 * RS > 3 * RC) ? 2 * RS : 3 * RC;
    localparam int SH_SQ = 2 * F + TWM - 2 * RS;
    localparam int SH_CB = 3 * F + TWM - 3 * RC;
    localparam int REMW  = 2 * RW + 6;
    localparam int SW    = 2 * RW;
    localparam int PW    = 32 + W;
    localparam int CWA   = $clog2(DW + 1);
    localparam int CWB   = $clog2(RW + 1);
    localparam int CWM   = (CWA > CWB) ? CWA : CWB;
    localparam int CW    = (W > CWM) ? W : CWM;
    localparam logic [63:0] ONE64  = 64'd1 << F;
    localparam logic [63:0] MASK64 = ONE64 - 64'd1;

    bk_state_t          state_reg, state_next;
    job_ctl_t           ctl_reg, ctl_next;
    logic [W-1:0]       ma_reg, ma_next;
    logic [W-1:0]       mb_reg, mb_next;
    logic [63:0]        mag_reg, mag_next;
    logic [PW-1:0]      prod_reg, prod_next;
    logic [63:0]        v_reg, v_next;
    logic               fixed_reg, fixed_next;
    status_t            stat_reg, stat_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [DW-1:0]      dq_reg, dq_next;
    logic [DW-1:0]      dr_reg, dr_next;
    logic [DW-1:0]      dd_reg, dd_next;
    logic [TWM-1:0]     t_reg, t_next;
    logic [RW-1:0]      r_reg, r_next;
    logic [SW-1:0]      s_reg, s_next;
    logic [REMW-1:0]    rem_reg, rem_next;
    logic               out_valid_reg, out_valid_next;
    logic [63:0]        whole_reg, whole_next;
    logic [15:0]        frac_reg, frac_next;
    status_t            status_reg, status_next;

    logic               slot_free;
    logic               simple_in;
    logic               j_fire;
    logic               last_step;
    logic [31:0]        mul_x;
    logic [W-1:0]       mul_y;
    logic [PW-1:0]      mul_p;
    logic [64:0]        p_sum;
    logic               pw_ovf;
    logic [63:0]        npw_d;
    logic               npw_big;
    logic [DW:0]        d_t;
    logic               d_ge;
    logic [DW:0]        d_sub;
    logic [DW-1:0]      dr_new;
    logic [DW-1:0]      dq_new;
    logic               is_cube;
    logic [REMW-1:0]    rem_x;
    logic [REMW-1:0]    r_test;
    logic               r_ge;
    logic [63:0]        v_simple;
    logic [63:0]        load_v;
    logic               load_fixed;
    status_t            load_stat;
    logic               out_load;

    assign slot_free = !out_valid_reg || out_ready;
    assign simple_in = (j_ctl.kind == JK_ADD) || (j_ctl.kind == JK_SUB)
                       || (j_ctl.kind == JK_FAULT);
    assign j_ready   = (state_reg == BK_IDLE) && (!simple_in || slot_free);
    assign j_fire    = j_valid && j_ready;
    assign last_step = (cnt_reg == CW'(1));

    // shared multiplier
    always_comb
    begin
        mul_y = (state_reg == BK_MUL) ? mb_reg : ma_reg;
        priority if (state_reg == BK_MUL)
            mul_x = 32'(ma_reg);
        else if (state_reg == BK_PHI)
            mul_x = mag_reg[63:32];
        else
            mul_x = mag_reg[31:0];
    end
    assign mul_p = PW'(mul_x) * PW'(mul_y);

    // power step: combine high partial product and check against the limit
    assign p_sum = 65'(mul_p) + 65'(prod_reg >> 32);
    assign pw_ovf = ctl_reg.neg
        ? ((p_sum[64:32] != '0)
           || (p_sum[31] && ((p_sum[30:0] != '0) || (prod_reg[31:0] != '0))))
        : (p_sum[64:31] != '0);

    assign npw_big = (64'(mul_p) > ONE64);
    assign npw_d   = npw_big ? (ONE64 + 64'd1) : 64'(mul_p);

    // restoring divide step
    assign d_t    = {dr_reg, dq_reg[DW-1]};
    assign d_sub  = d_t - {1'b0, dd_reg};
    assign d_ge   = (d_t >= {1'b0, dd_reg});
    assign dr_new = d_ge ? d_sub[DW-1:0] : d_t[DW-1:0];
    assign dq_new = {dq_reg[DW-2:0], d_ge};

    // digit-by-digit root step
    assign is_cube = (ctl_reg.kind == JK_CBRT);
    assign rem_x = is_cube ? ((rem_reg << 3) | REMW'(t_reg[TWM-1 -: 3]))
                           : ((rem_reg << 2) | REMW'(t_reg[TWM-1 -: 2]));
    assign r_test = is_cube
        ? ((REMW'(s_reg) << 3) + (REMW'(s_reg) << 2) + (REMW'(r_reg) << 2)
           + (REMW'(r_reg) << 1) + REMW'(1))
        : ((REMW'(r_reg) << 2) | REMW'(1));
    assign r_ge = (rem_x >= r_test);

    always_comb
    begin
        unique case (j_ctl.kind)
            JK_ADD:  v_simple = 64'($signed(j_a)) + 64'($signed(j_b));
            JK_SUB:  v_simple = 64'($signed(j_a)) - 64'($signed(j_b));
            default: v_simple = '0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (j_fire)
                begin
                    unique case (j_ctl.kind)
                        JK_MUL:  state_next = BK_MUL;
                        JK_DIV,
                        JK_REM:  state_next = BK_DIV;
                        JK_PPOW: state_next = ((j_mb == '0) || (j_ma <= W'(1)))
                                              ? BK_SIGN : BK_PLO;
                        JK_NPOW: state_next = (j_ma <= W'(1)) ? BK_DSET : BK_NPW;
                        JK_SQRT,
                        JK_CBRT: state_next = BK_ROOT;
                        default: state_next = BK_IDLE;
                    endcase
                end
            end
            BK_MUL:  state_next = BK_SIGN;
            BK_PLO:  state_next = BK_PHI;
            BK_PHI:
            begin
                priority if (pw_ovf)
                    state_next = BK_FIN;
                else if (last_step)
                    state_next = BK_SIGN;
                else
                    state_next = BK_PLO;
            end
            BK_NPW:  state_next = (npw_big || last_step) ? BK_DSET : BK_NPW;
            BK_DSET: state_next = BK_DIV;
            BK_DIV:  state_next = last_step ? BK_SIGN : BK_DIV;
            BK_ROOT: state_next = last_step ? BK_RFIX : BK_ROOT;
            BK_RFIX: state_next = BK_SIGN;
            BK_SIGN: state_next = BK_FIN;
            BK_FIN:  state_next = slot_free ? BK_IDLE : BK_FIN;
            default: state_next = BK_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        ctl_next   = ctl_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        mag_next   = mag_reg;
        prod_next  = prod_reg;
        v_next     = v_reg;
        fixed_next = fixed_reg;
        stat_next  = stat_reg;
        cnt_next   = cnt_reg;
        dq_next    = dq_reg;
        dr_next    = dr_reg;
        dd_next    = dd_reg;
        t_next     = t_reg;
        r_next     = r_reg;
        s_next     = s_reg;
        rem_next   = rem_reg;
        load_v     = v_simple;
        load_fixed = 1'b0;
        load_stat  = (j_ctl.kind == JK_FAULT) ? j_ctl.fault : ST_OK;
        out_load   = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (j_fire)
                begin
                    ctl_next   = j_ctl;
                    ma_next    = j_ma;
                    mb_next    = j_mb;
                    stat_next  = ST_OK;
                    fixed_next = (j_ctl.kind == JK_NPOW) || (j_ctl.kind == JK_SQRT)
                                 || (j_ctl.kind == JK_CBRT);
                    out_load   = simple_in;
                    unique case (j_ctl.kind)
                        JK_DIV,
                        JK_REM:
                        begin
                            dq_next  = DW'(j_ma);
                            dd_next  = DW'(j_mb);
                            dr_next  = '0;
                            cnt_next = CW'(DW);
                        end
                        JK_PPOW:
                        begin
                            priority if (j_mb == '0)
                                mag_next = 64'd1;
                            else if (j_ma <= W'(1))
                                mag_next = 64'(j_ma);
                            else
                                mag_next = 64'd1;
                            cnt_next = CW'(j_mb);
                        end
                        JK_NPOW:
                        begin
                            mag_next = 64'd1;
                            cnt_next = CW'(j_mb);
                        end
                        JK_SQRT:
                        begin
                            t_next   = TWM'(j_ma) << SH_SQ;
                            r_next   = '0;
                            s_next   = '0;
                            rem_next = '0;
                            cnt_next = CW'(RS);
                        end
                        JK_CBRT:
                        begin
                            t_next   = TWM'(j_ma) << SH_CB;
                            r_next   = '0;
                            s_next   = '0;
                            rem_next = '0;
                            cnt_next = CW'(RC);
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            BK_MUL:  mag_next = 64'(mul_p);
            BK_PLO:  prod_next = mul_p;
            BK_PHI:
            begin
                cnt_next = cnt_reg - CW'(1);
                mag_next = {p_sum[31:0], prod_reg[31:0]};
                if (pw_ovf)
                begin
                    v_next     = ctl_reg.neg ? 64'h8000_0000_0000_0000
                                             : 64'h7FFF_FFFF_FFFF_FFFF;
                    stat_next  = ST_OVERFLOW;
                    fixed_next = 1'b0;
                end
            end
            BK_NPW:
            begin
                cnt_next = cnt_reg - CW'(1);
                mag_next = npw_d;
            end
            BK_DSET:
            begin
                // round toward minus infinity: ceiling on the magnitude when negative
                dq_next  = DW'(ONE64) + (ctl_reg.neg ? DW'(mag_reg - 64'd1) : DW'(0));
                dd_next  = DW'(mag_reg);
                dr_next  = '0;
                cnt_next = CW'(DW);
            end
            BK_DIV:
            begin
                cnt_next = cnt_reg - CW'(1);
                dq_next  = dq_new;
                dr_next  = dr_new;
                mag_next = (ctl_reg.kind == JK_REM) ? 64'(dr_new) : 64'(dq_new);
            end
            BK_ROOT:
            begin
                cnt_next = cnt_reg - CW'(1);
                t_next   = is_cube ? (t_reg << 3) : (t_reg << 2);
                rem_next = r_ge ? (rem_x - r_test) : rem_x;
                r_next   = {r_reg[RW-2:0], r_ge};
                s_next   = r_ge ? ((s_reg << 2) + (SW'(r_reg) << 2) + SW'(1)) : (s_reg << 2);
            end
            BK_RFIX:
            begin
                // inexact negative cube root steps one unit further down
                mag_next = 64'(r_reg)
                           + 64'(is_cube && ctl_reg.neg && (rem_reg != '0));
            end
            BK_SIGN:
            begin
                v_next = ctl_reg.neg ? (~mag_reg + 64'd1) : mag_reg;
            end
            BK_FIN:
            begin
                load_v     = v_reg;
                load_fixed = fixed_reg;
                load_stat  = stat_reg;
                out_load   = slot_free;
            end
            default:
            begin
            end
        endcase

        out_valid_next = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
        whole_next     = whole_reg;
        frac_next      = frac_reg;
        status_next    = status_reg;
        if (out_load)
        begin
            whole_next  = load_fixed ? 64'($signed(load_v) >>> F) : load_v;
            frac_next   = load_fixed ? 16'(load_v & MASK64) : 16'd0;
            status_next = load_stat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ctl_reg    <= ctl_next;
        ma_reg     <= ma_next;
        mb_reg     <= mb_next;
        mag_reg    <= mag_next;
        prod_reg   <= prod_next;
        v_reg      <= v_next;
        fixed_reg  <= fixed_next;
        stat_reg   <= stat_next;
        cnt_reg    <= cnt_next;
        dq_reg     <= dq_next;
        dr_reg     <= dr_next;
        dd_reg     <= dd_next;
        t_reg      <= t_next;
        r_reg      <= r_next;
        s_reg      <= s_next;
        rem_reg    <= rem_next;
        whole_reg  <= whole_next;
        frac_reg   <= frac_next;
        status_reg <= status_next;
    end

    assign out_valid       = out_valid_reg;
    assign result_whole    = whole_reg;
    assign result_fraction = frac_reg;
    assign status          = status_reg;

    a_ovf_frac: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == ST_OVERFLOW)) |-> (frac_reg == '0))
        else $error("saturated word carries a fraction");

    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ((status_reg == ST_DIV_ZERO) || (status_reg == ST_ROOT_NEG)))
        |-> ((whole_reg == '0) && (frac_reg == '0)))
        else $error("fault word is not zero");

    a_busy_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != BK_IDLE) |-> !j_ready)
        else $error("job taken while sequencer busy");

    a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == BK_ROOT) || (state_reg == BK_DIV)) |-> (cnt_reg != '0))
        else $error("iteration count ran out inside a loop");

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// Self-checking testbench for the integer calculator ALU with a built-in result predictor.
`timescale 1ns / 1ps

module tb_top;
    import icalc_pkg::*;

    typedef struct {
        logic signed [63:0] whole;
        logic [15:0]        fraction;
        logic [1:0]         stat;
    } calc_word_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [2:0]         operation = OP_ADD;
    logic signed [31:0] first_operand = '0;
    logic signed [31:0] second_operand = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [63:0] result_whole;
    logic [15:0]        result_fraction;
    logic [1:0]         status;

    calc_word_t expected_words[$];
    int         fail_count = 0;
    bit         quiet_tail = 1'b0;

    localparam int FRAC = 16;

    always #2 clk = ~clk;

    integer_calculator_alu_top DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .first_operand(first_operand),
        .second_operand(second_operand),
        .out_valid(out_valid), .out_ready(out_ready),
        .result_whole(result_whole), .result_fraction(result_fraction),
        .status(status)
    );

    // floor of the k-th root of x * 2^(k*FRAC), plus whether it is exact
    function automatic logic [63:0] fixed_root(logic [63:0] x, int k, output bit exact);
        logic [127:0] target;
        logic [127:0] p;
        logic [63:0]  r;
        logic [63:0]  c;
        target = {64'd0, x} << (k * FRAC);
        r = '0;
        for (int b = 41; b >= 0; b--)
        begin
            c = r | (64'd1 << b);
            p = (k == 2) ? c * c : c * c * c;
            if (p <= target)
                r = c;
        end
        p = (k == 2) ? r * r : r * r * r;
        exact = (p == target);
        return r;
    endfunction

    function automatic calc_word_t split_fixed(logic signed [63:0] q);
        calc_word_t w;
        w.fraction = q[15:0];
        w.whole = q >>> FRAC;
        w.stat = ST_OK;
        return w;
    endfunction

    function automatic calc_word_t calc_result(logic [2:0] op, logic signed [31:0] fa,
                                               logic signed [31:0] sb);
        calc_word_t w;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic [63:0] mag_a;
        logic [63:0] mag;
        logic [63:0] lim;
        logic [63:0] d;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] n;
        bit neg;
        bit exact;
        a = fa;
        b = sb;
        mag_a = (a < 0) ? -a : a;
        w.whole = '0;
        w.fraction = '0;
        w.stat = ST_OK;
        case (op)
            OP_ADD: w.whole = a + b;
            OP_SUB: w.whole = a - b;
            OP_MUL: w.whole = a * b;
            OP_DIV:
                if (b == 0) w.stat = ST_DIV_ZERO; else w.whole = a / b;
            OP_REM:
                if (b == 0) w.stat = ST_DIV_ZERO; else w.whole = a % b;
            OP_POW:
                if (b >= 0)
                begin
                    n = b;
                    neg = (a < 0) && n[0];
                    lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
                    mag = 1;
                    if (n == 0) mag = 1;
                    else if (mag_a <= 1) mag = mag_a;
                    else
                    begin
                        for (longint i = 0; i < n; i++)
                        begin
                            if (mag > lim / mag_a)
                            begin
                                w.stat = ST_OVERFLOW;
                                break;
                            end
                            mag = mag * mag_a;
                        end
                    end
                    if (w.stat == ST_OVERFLOW)
                        w.whole = neg ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
                    else
                        w.whole = neg ? -mag : mag;
                end
                else if (a == 0)
                    w.stat = ST_DIV_ZERO;
                else
                begin
                    n = -b;
                    neg = (a < 0) && n[0];
                    d = 1;
                    if (mag_a > 1)
                        for (longint i = 0; i < n && d <= (64'd1 << FRAC); i++)
                        begin
                            d = d * mag_a;
                            if (d > (64'd1 << FRAC)) d = (64'd1 << FRAC) + 1;
                        end
                    if (!neg)
                        w = split_fixed((64'd1 << FRAC) / d);
                    else
                    begin
                        q = ((64'd1 << FRAC) + d - 1) / d;
                        w = split_fixed(-q);
                    end
                end
            OP_SQRT:
                if (a < 0) w.stat = ST_ROOT_NEG;
                else w = split_fixed(fixed_root(mag_a, 2, exact));
            default:
            begin
                r = fixed_root(mag_a, 3, exact);
                if (a >= 0) w = split_fixed(r);
                else w = split_fixed(exact ? -r : -(r + 1));
            end
        endcase
        return w;
    endfunction

    // drop valid only while idling, so back-to-back words keep it high
    task automatic random_gap();
        if (!quiet_tail && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    task automatic send_word(logic [2:0] op, logic signed [31:0] fa, logic signed [31:0] sb);
        random_gap();
        in_valid <= 1'b1;
        operation <= op;
        first_operand <= fa;
        second_operand <= sb;
        expected_words.push_back(calc_result(op, fa, sb));
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // receiver stalls in random bursts
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!quiet_tail && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        calc_word_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected word whole=%0d frac=%0d status=%0d",
                         $time, result_whole, result_fraction, status);
                fail_count++;
            end
            else
            begin
                e = expected_words.pop_front();
                if (result_whole !== e.whole)
                begin
                    $display("%0t: whole expected %0d actual %0d", $time, e.whole, result_whole);
                    fail_count++;
                end
                if (result_fraction !== e.fraction)
                begin
                    $display("%0t: fraction expected %0d actual %0d",
                             $time, e.fraction, result_fraction);
                    fail_count++;
                end
                if (status !== e.stat)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, e.stat, status);
                    fail_count++;
                end
            end
        end
    end

    function automatic logic signed [31:0] rand_operand();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 20) - 10;
            1: return $urandom_range(0, 4) ? $urandom_range(0, 70000) : 32'sh8000_0000;
            2: return -$signed($urandom_range(0, 70000));
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        logic signed [31:0] mn;
        logic signed [31:0] mx;
        mn = 32'sh8000_0000;
        mx = 32'sh7FFF_FFFF;
        send_word(OP_ADD, mx, mx);
        send_word(OP_SUB, mn, mx);
        send_word(OP_MUL, mn, mn);
        send_word(OP_DIV, mn, -1);
        send_word(OP_DIV, 7, 0);
        send_word(OP_DIV, -7, 2);
        send_word(OP_REM, -7, 2);
        send_word(OP_REM, 5, 0);
        send_word(OP_POW, 0, 0);
        send_word(OP_POW, 0, -3);
        send_word(OP_POW, -3, -1);
        send_word(OP_POW, 2, -20);
        send_word(OP_POW, 2, 63);
        send_word(OP_POW, -2, 63);
        send_word(OP_POW, mx, mx);
        send_word(OP_POW, mn, 3);
        send_word(OP_POW, -1, mn);
        send_word(OP_SQRT, -1, 0);
        send_word(OP_SQRT, mx, 0);
        send_word(OP_SQRT, 2, 0);
        send_word(OP_CBRT, -27, 0);
        send_word(OP_CBRT, -2, 0);
        send_word(OP_CBRT, mn, 0);
        send_word(OP_CBRT, mx, -1);
    endtask

    task automatic test_random(int count);
        logic [2:0] op;
        logic signed [31:0] sb;
        for (int i = 0; i < count; i++)
        begin
            op = $urandom_range(0, 7);
            sb = rand_operand();
            // keep most exponents small so power does not always saturate
            if (op == OP_POW && $urandom_range(0, 3) != 0)
                sb = $signed($urandom_range(0, 80)) - 20;
            send_word(op, rand_operand(), sb);
        end
    endtask

    task automatic test_no_idle();
        quiet_tail = 1'b1;
        test_random(100);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(730);
        test_no_idle();
        in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
